/* src/scp_pkg.sv */
`timescale 1ns / 1ps

package scp_pkg;

   localparam int LINE_DEPTH        = 32;
   localparam int MAX_PAYLOAD_BYTES = 12;

   // Count and pointer hold values up to LINE_DEPTH itself.
   localparam int CNT_W  = $clog2(LINE_DEPTH + 1);
   localparam int ADDR_W = $clog2(LINE_DEPTH);
   localparam int PAY_W  = $clog2(MAX_PAYLOAD_BYTES + 1);
   localparam int CMP_W  = ((CNT_W > 8) ? CNT_W : 8) + 1;

   // The first bytes of the line are shadowed in registers for prefix matching.
   localparam int HEAD_DEPTH = 7;
   localparam int HEAD_W     = 3;

   localparam int SEND_FIRST_OFFSET  = 4;
   localparam int RADIO_FIRST_OFFSET = 16;
   localparam int RADIO_FIRST_DIGITS = 5;
   localparam int RADIO_SECOND_DIGITS = 3;

   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_1      = 8'h31;
   localparam logic [7:0] CH_3      = 8'h33;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_A      = 8'h41;
   localparam logic [7:0] CH_F      = 8'h46;
   localparam logic [7:0] CH_I      = 8'h49;
   localparam logic [7:0] CH_M      = 8'h4D;
   localparam logic [7:0] CH_S      = 8'h53;
   localparam logic [7:0] CH_T      = 8'h54;
   localparam logic [7:0] CH_Z      = 8'h5A;

   typedef enum logic [1:0] {
      CMD_SEND    = 2'd0,
      CMD_VERSION = 2'd1,
      CMD_RADIO   = 2'd2,
      CMD_AT      = 2'd3
   } command_type;

   function automatic logic [7:0] hex_ascii(input logic [3:0] nibble);
      logic [7:0] code;
      if (nibble < 4'd10) begin
         code = CH_0 + {4'b0000, nibble};
      end else begin
         code = CH_A + {4'b0000, nibble} - 8'd10;
      end
      return code;
   endfunction

endpackage

/* src/serial_command_line_parser.sv */
`timescale 1ns / 1ps

// Serial command line parser.
// The req channel takes one received serial byte per transfer. Ordinary bytes
// are stored once a capital letter has opened the line; the block stays ready.
// A newline or semicolon starts decoding: the S_MATCH state matches the stored
// line against the SFM, ATI13, AT$IF= and AT prefixes using a register copy
// of the first seven bytes. The rsp channel then carries the results from an
// output register. A sensor send gives two results per payload byte, up to
// twelve bytes, each byte taking one line store read (S_SFETCH, S_SHI) and then
// one result transfer per hex character (S_WHI, S_WLO). A radio config command
// reads its digits one at a time, a fetch and a use state per digit, through
// one shared multiply-by-ten unit. Version and AT commands offer their result
// once the S_MATCH state has decoded the terminated line.
// The block takes no byte while a line is being decoded or a result waits.
// A stalled receiver simply holds the block in its current result.
// Reset clears the state, the line count, the head copy, the line store valid
// bits and the output valid; the store reads as zeros until written.
module serial_command_line_parser
   import scp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_command,
   output logic [15:0] rsp_node_id,
   output logic [7:0]  rsp_cca_threshold,
   output logic [7:0]  rsp_tx_power,
   output logic [7:0]  rsp_hex_char,
   output logic        rsp_char_valid,
   output logic        rsp_last
);

   typedef enum logic [10:0] {
      S_IDLE    = 11'b00000000001,
      S_MATCH   = 11'b00000000010,
      S_SFETCH  = 11'b00000000100,
      S_SHI     = 11'b00000001000,
      S_WHI     = 11'b00000010000,
      S_WLO     = 11'b00000100000,
      S_P1FETCH = 11'b00001000000,
      S_P1USE   = 11'b00010000000,
      S_P2FETCH = 11'b00100000000,
      S_P2USE   = 11'b01000000000,
      S_WEND    = 11'b10000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  end_ptr_ff, end_ptr_in;
   logic [2:0]        digit_cnt_ff, digit_cnt_in;
   logic [7:0]        acc1_ff, acc1_in;
   logic [7:0]        acc2_ff, acc2_in;

   logic [7:0]        mem [LINE_DEPTH];
   logic [LINE_DEPTH-1:0] entry_valid_ff;
   logic [7:0]        head_ff [HEAD_DEPTH];
   logic [7:0]        rd_data_ff;
   logic              rd_ok_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   command_type       rsp_command_ff, rsp_command_in;
   logic [15:0]       rsp_node_ff, rsp_node_in;
   logic [7:0]        rsp_cca_ff, rsp_cca_in;
   logic [7:0]        rsp_txp_ff, rsp_txp_in;
   logic [7:0]        rsp_hex_ff, rsp_hex_in;
   logic              rsp_cv_ff, rsp_cv_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_fire;
   logic              is_term;
   logic              is_upper;
   logic              wr_en;
   logic              rd_en;
   logic [7:0]        rd_byte;
   logic              is_digit;
   logic [7:0]        acc_sel;
   logic [7:0]        acc_next;
   logic              m_sfm, m_ver, m_radio, m_at;
   logic [7:0]        plen;
   logic              send_short;
   logic [PAY_W-1:0]  send_bytes;
   logic [15:0]       node;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign is_term   = (req_rx_byte == CH_LF) || (req_rx_byte == CH_SEMI);
   assign is_upper  = (req_rx_byte >= CH_A) && (req_rx_byte <= CH_Z);

   always_comb begin
      wr_en = 1'b0;
      if (req_fire && (count_ff < CNT_W'(LINE_DEPTH))) begin
         if (is_term) begin
            wr_en = (count_ff != '0);
         end else begin
            wr_en = (count_ff != '0) || is_upper;
         end
      end
   end

   assign rd_en = (state_ff == S_SFETCH) || (state_ff == S_P1FETCH) ||
                  (state_ff == S_P2FETCH);

   // Unwritten entries and addresses past the store read as zero.
   assign rd_byte  = rd_ok_ff ? rd_data_ff : 8'd0;
   assign is_digit = (rd_byte >= CH_0) && (rd_byte <= CH_9);

   // Shared decimal accumulate unit: acc * 10 + digit, kept to eight bits.
   assign acc_sel  = (state_ff == S_P1USE) ? acc1_ff : acc2_ff;
   assign acc_next = 8'({acc_sel, 3'b000} + {2'b00, acc_sel, 1'b0}) + (rd_byte - CH_0);

   // Prefix matching on the shadowed head of the line.
   assign m_sfm   = (count_ff >= CNT_W'(3)) && (head_ff[0] == CH_S) &&
                    (head_ff[1] == CH_F) && (head_ff[2] == CH_M);
   assign m_ver   = (count_ff >= CNT_W'(5)) && (head_ff[0] == CH_A) &&
                    (head_ff[1] == CH_T) && (head_ff[2] == CH_I) &&
                    (head_ff[3] == CH_1) && (head_ff[4] == CH_3);
   assign m_radio = (count_ff >= CNT_W'(6)) && (head_ff[0] == CH_A) &&
                    (head_ff[1] == CH_T) && (head_ff[2] == CH_DOLLAR) &&
                    (head_ff[3] == CH_I) && (head_ff[4] == CH_F) &&
                    (head_ff[5] == CH_EQUAL);
   assign m_at    = (count_ff >= CNT_W'(2)) && (head_ff[0] == CH_A) &&
                    (head_ff[1] == CH_T);

   assign plen       = head_ff[3];
   assign send_short = (CMP_W'(plen) + CMP_W'(5)) > CMP_W'(count_ff);
   assign send_bytes = (plen < 8'(MAX_PAYLOAD_BYTES)) ? PAY_W'(plen)
                                                       : PAY_W'(MAX_PAYLOAD_BYTES);
   assign node       = {head_ff[5], head_ff[6]};

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      ptr_in         = ptr_ff;
      end_ptr_in     = end_ptr_ff;
      digit_cnt_in   = digit_cnt_ff;
      acc1_in        = acc1_ff;
      acc2_in        = acc2_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_command_in = rsp_command_ff;
      rsp_node_in    = rsp_node_ff;
      rsp_cca_in     = rsp_cca_ff;
      rsp_txp_in     = rsp_txp_ff;
      rsp_hex_in     = rsp_hex_ff;
      rsp_cv_in      = rsp_cv_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (wr_en) begin
               count_in = count_ff + CNT_W'(1);
            end
            if (req_fire && is_term && (count_ff != '0)) begin
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            count_in = '0;
            state_in = S_IDLE;
            priority if (m_sfm) begin
               if (send_short) begin
                  // Collection goes on with the terminator left in the line.
                  count_in = count_ff;
               end else if (send_bytes == '0) begin
                  rsp_valid_in   = 1'b1;
                  rsp_command_in = CMD_SEND;
                  rsp_node_in    = node;
                  rsp_cca_in     = 8'd0;
                  rsp_txp_in     = 8'd0;
                  rsp_hex_in     = 8'd0;
                  rsp_cv_in      = 1'b0;
                  rsp_last_in    = 1'b1;
                  state_in       = S_WEND;
               end else begin
                  ptr_in     = CNT_W'(SEND_FIRST_OFFSET);
                  end_ptr_in = CNT_W'(SEND_FIRST_OFFSET - 1) + CNT_W'(send_bytes);
                  state_in   = S_SFETCH;
               end
            end else if (m_ver) begin
               rsp_valid_in   = 1'b1;
               rsp_command_in = CMD_VERSION;
               rsp_node_in    = 16'd0;
               rsp_cca_in     = 8'd0;
               rsp_txp_in     = 8'd0;
               rsp_hex_in     = 8'd0;
               rsp_cv_in      = 1'b0;
               rsp_last_in    = 1'b1;
               state_in       = S_WEND;
            end else if (m_radio) begin
               ptr_in       = CNT_W'(RADIO_FIRST_OFFSET);
               digit_cnt_in = '0;
               acc1_in      = 8'd0;
               acc2_in      = 8'd0;
               state_in     = S_P1FETCH;
            end else if (m_at) begin
               rsp_valid_in   = 1'b1;
               rsp_command_in = CMD_AT;
               rsp_node_in    = 16'd0;
               rsp_cca_in     = 8'd0;
               rsp_txp_in     = 8'd0;
               rsp_hex_in     = 8'd0;
               rsp_cv_in      = 1'b0;
               rsp_last_in    = 1'b1;
               state_in       = S_WEND;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SFETCH: begin
            state_in = S_SHI;
         end
         S_SHI: begin
            rsp_valid_in   = 1'b1;
            rsp_command_in = CMD_SEND;
            rsp_node_in    = node;
            rsp_cca_in     = 8'd0;
            rsp_txp_in     = 8'd0;
            rsp_hex_in     = hex_ascii(rd_byte[7:4]);
            rsp_cv_in      = 1'b1;
            rsp_last_in    = 1'b0;
            state_in       = S_WHI;
         end
         S_WHI: begin
            if (rsp_ready) begin
               rsp_hex_in  = hex_ascii(rd_byte[3:0]);
               rsp_last_in = (ptr_ff == end_ptr_ff);
               state_in    = S_WLO;
            end
         end
         S_WLO: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (ptr_ff == end_ptr_ff) begin
                  state_in = S_IDLE;
               end else begin
                  ptr_in   = ptr_ff + CNT_W'(1);
                  state_in = S_SFETCH;
               end
            end
         end
         S_P1FETCH: begin
            state_in = S_P1USE;
         end
         S_P1USE: begin
            if (is_digit) begin
               acc1_in = acc_next;
               if (digit_cnt_ff == 3'(RADIO_FIRST_DIGITS - 1)) begin
                  // The second value starts two past the last digit, after one separator byte.
                  ptr_in       = ptr_ff + CNT_W'(2);
                  digit_cnt_in = '0;
                  state_in     = S_P2FETCH;
               end else begin
                  ptr_in       = ptr_ff + CNT_W'(1);
                  digit_cnt_in = digit_cnt_ff + 3'd1;
                  state_in     = S_P1FETCH;
               end
            end else begin
               ptr_in       = ptr_ff + CNT_W'(1);
               digit_cnt_in = '0;
               state_in     = S_P2FETCH;
            end
         end
         S_P2FETCH: begin
            state_in = S_P2USE;
         end
         S_P2USE: begin
            if (is_digit && (digit_cnt_ff != 3'(RADIO_SECOND_DIGITS - 1))) begin
               acc2_in      = acc_next;
               ptr_in       = ptr_ff + CNT_W'(1);
               digit_cnt_in = digit_cnt_ff + 3'd1;
               state_in     = S_P2FETCH;
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_command_in = CMD_RADIO;
               rsp_node_in    = 16'd0;
               rsp_cca_in     = acc1_ff;
               rsp_txp_in     = is_digit ? acc_next : acc2_ff;
               rsp_hex_in     = 8'd0;
               rsp_cv_in      = 1'b0;
               rsp_last_in    = 1'b1;
               state_in       = S_WEND;
            end
         end
         S_WEND: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
         for (int i = 0; i < HEAD_DEPTH; i++) begin
            head_ff[i] <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            entry_valid_ff[count_ff[ADDR_W-1:0]] <= 1'b1;
            if (count_ff < CNT_W'(HEAD_DEPTH)) begin
               head_ff[count_ff[HEAD_W-1:0]] <= req_rx_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      end_ptr_ff     <= end_ptr_in;
      digit_cnt_ff   <= digit_cnt_in;
      acc1_ff        <= acc1_in;
      acc2_ff        <= acc2_in;
      rsp_command_ff <= rsp_command_in;
      rsp_node_ff    <= rsp_node_in;
      rsp_cca_ff     <= rsp_cca_in;
      rsp_txp_ff     <= rsp_txp_in;
      rsp_hex_ff     <= rsp_hex_in;
      rsp_cv_ff      <= rsp_cv_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Line store: one write port in the idle state, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[ADDR_W-1:0]] <= req_rx_byte;
      end
      if (rd_en) begin
         rd_data_ff <= mem[ptr_ff[ADDR_W-1:0]];
         rd_ok_ff   <= (ptr_ff < CNT_W'(LINE_DEPTH)) &&
                       entry_valid_ff[ptr_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_command       = rsp_command_ff;
   assign rsp_node_id       = rsp_node_ff;
   assign rsp_cca_threshold = rsp_cca_ff;
   assign rsp_tx_power      = rsp_txp_ff;
   assign rsp_hex_char      = rsp_hex_ff;
   assign rsp_char_valid    = rsp_cv_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

/* src/scp_checker.sv */
`timescale 1ns / 1ps

module scp_checker
   import scp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_command,
   input logic [15:0] rsp_node_id,
   input logic [7:0]  rsp_cca_threshold,
   input logic [7:0]  rsp_tx_power,
   input logic [7:0]  rsp_hex_char,
   input logic        rsp_char_valid,
   input logic        rsp_last
);

   // A result that is not taken stays offered unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_command) &&
      $stable(rsp_node_id) && $stable(rsp_cca_threshold) && $stable(rsp_tx_power) &&
      $stable(rsp_hex_char) && $stable(rsp_char_valid) && $stable(rsp_last))
      else $error("result changed while stalled");

   // No byte is taken while a result is pending.
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("byte taken while a result is pending");

   // Payload characters belong to a send command and are hex digits.
   a_hex_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_valid |-> (rsp_command == CMD_SEND) &&
      (((rsp_hex_char >= CH_0) && (rsp_hex_char <= CH_9)) ||
       ((rsp_hex_char >= CH_A) && (rsp_hex_char <= CH_F))))
      else $error("bad payload character");

   // Commands other than a send finish in a single result.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command != CMD_SEND) |-> rsp_last && !rsp_char_valid)
      else $error("non-send command with more than one result");

endmodule

bind serial_command_line_parser scp_checker u_scp_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench
   import scp_pkg::*;
();

   localparam int RANDOM_ITEMS = 180;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 60;
   localparam int MAX_GAP      = 40;
   localparam int SCRIPT_LEN   = 27;

   typedef struct packed {
      command_type command;
      logic [15:0] node_id;
      logic [7:0]  cca_threshold;
      logic [7:0]  tx_power;
      logic [7:0]  hex_char;
      logic        char_valid;
      logic        last;
   } parse_result_type;

   // A typed row carries its one bare result directly; other rows go through
   // the line predictor.
   typedef struct packed {
      logic [7:0]  rx_byte;
      logic        typed;
      command_type command;
      logic [15:0] node_id;
   } script_row_type;

   typedef enum int {
      LINE_SEND,
      LINE_RADIO,
      LINE_VERSION,
      LINE_AT,
      LINE_NOMATCH,
      LINE_NOISE,
      LINE_LONG,
      LINE_TERM
   } line_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_command;
   logic [15:0] rsp_node_id;
   logic [7:0]  rsp_cca_threshold;
   logic [7:0]  rsp_tx_power;
   logic [7:0]  rsp_hex_char;
   logic        rsp_char_valid;
   logic        rsp_last;

   serial_command_line_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_command       (rsp_command),
      .rsp_node_id       (rsp_node_id),
      .rsp_cca_threshold (rsp_cca_threshold),
      .rsp_tx_power      (rsp_tx_power),
      .rsp_hex_char      (rsp_hex_char),
      .rsp_char_valid    (rsp_char_valid),
      .rsp_last          (rsp_last)
   );

   logic [7:0]       line_buf [0:LINE_DEPTH-1];
   int               line_len;
   parse_result_type fresh_results[$];
   parse_result_type expected_results[$];
   int               errors = 0;
   int               items_sent = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               hold_requests = 0;
   int               hold_served = 0;
   int               hold_left = 0;
   int               cycle_count = 0;

   script_row_type script [SCRIPT_LEN] = '{
      '{8'h00,     1'b0, CMD_SEND,    16'h0000},
      '{8'hFF,     1'b0, CMD_SEND,    16'h0000},
      '{CH_LF,     1'b0, CMD_SEND,    16'h0000},
      '{CH_A,      1'b0, CMD_SEND,    16'h0000},
      '{CH_T,      1'b0, CMD_SEND,    16'h0000},
      '{CH_SEMI,   1'b1, CMD_AT,      16'h0000},
      '{CH_A,      1'b0, CMD_SEND,    16'h0000},
      '{CH_T,      1'b0, CMD_SEND,    16'h0000},
      '{CH_I,      1'b0, CMD_SEND,    16'h0000},
      '{CH_1,      1'b0, CMD_SEND,    16'h0000},
      '{CH_3,      1'b0, CMD_SEND,    16'h0000},
      '{CH_LF,     1'b1, CMD_VERSION, 16'h0000},
      '{CH_S,      1'b0, CMD_SEND,    16'h0000},
      '{CH_F,      1'b0, CMD_SEND,    16'h0000},
      '{CH_M,      1'b0, CMD_SEND,    16'h0000},
      '{8'h00,     1'b0, CMD_SEND,    16'h0000},
      '{8'h7F,     1'b0, CMD_SEND,    16'h0000},
      '{8'hFF,     1'b0, CMD_SEND,    16'h0000},
      '{8'hFF,     1'b0, CMD_SEND,    16'h0000},
      '{CH_SEMI,   1'b1, CMD_SEND,    16'hFFFF},
      '{CH_A,      1'b0, CMD_SEND,    16'h0000},
      '{CH_T,      1'b0, CMD_SEND,    16'h0000},
      '{CH_DOLLAR, 1'b0, CMD_SEND,    16'h0000},
      '{CH_I,      1'b0, CMD_SEND,    16'h0000},
      '{CH_F,      1'b0, CMD_SEND,    16'h0000},
      '{CH_EQUAL,  1'b0, CMD_SEND,    16'h0000},
      '{CH_LF,     1'b1, CMD_RADIO,   16'h0000}
   };

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] line_byte(input int idx);
      if (idx < LINE_DEPTH) begin
         return line_buf[idx];
      end
      return 8'h00;
   endfunction

   function automatic bit line_has_prefix(input string text);
      if (text.len() > line_len) begin
         return 1'b0;
      end
      for (int i = 0; i < text.len(); i++) begin
         if (line_byte(i) != text[i]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // The value wraps at eight bits after every digit; the count of digits
   // taken is returned.
   function automatic int read_decimal(input int start, input int max_digits,
                                       output logic [7:0] value);
      int         n;
      logic [7:0] c;
      n = 0;
      value = 8'h00;
      while (n < max_digits) begin
         c = line_byte(start + n);
         if (c < CH_0 || c > CH_9) begin
            break;
         end
         value = value * 8'd10 + (c - CH_0);
         n++;
      end
      return n;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      return {4'h0, nib} + ((nib < 4'd10) ? CH_0 : CH_A - 8'd10);
   endfunction

   // Updates the line state for one byte and leaves the results it causes in
   // fresh_results. Returns 0 when the byte is simply ignored.
   function automatic bit predict_byte(input logic [7:0] rx);
      logic [7:0]       plen;
      logic [7:0]       cca;
      logic [7:0]       txp;
      logic [7:0]       b;
      int               payload;
      int               digits;
      parse_result_type r;
      fresh_results.delete();
      if (rx != CH_LF && rx != CH_SEMI) begin
         if (line_len == 0 && (rx < CH_A || rx > CH_Z)) begin
            return 1'b0;
         end
         if (line_len < LINE_DEPTH) begin
            line_buf[line_len] = rx;
            line_len++;
         end
         return 1'b1;
      end
      if (line_len == 0) begin
         return 1'b0;
      end
      if (line_len < LINE_DEPTH) begin
         line_buf[line_len] = rx;
         line_len++;
      end
      r = '0;
      r.last = 1'b1;
      if (line_has_prefix("SFM")) begin
         plen = line_byte(3);
         // A short send keeps the line, terminator included, and collects on.
         if (5 + int'(plen) > line_len) begin
            return 1'b1;
         end
         payload = (plen < MAX_PAYLOAD_BYTES) ? int'(plen) : MAX_PAYLOAD_BYTES;
         r.command = CMD_SEND;
         r.node_id = {line_byte(5), line_byte(6)};
         if (payload == 0) begin
            fresh_results.push_back(r);
         end
         for (int i = 0; i < payload; i++) begin
            b = line_byte(SEND_FIRST_OFFSET + i);
            r.char_valid = 1'b1;
            r.hex_char = hex_digit(b[7:4]);
            r.last = 1'b0;
            fresh_results.push_back(r);
            r.hex_char = hex_digit(b[3:0]);
            r.last = (i == payload - 1);
            fresh_results.push_back(r);
         end
      end else if (line_has_prefix("ATI13")) begin
         r.command = CMD_VERSION;
         fresh_results.push_back(r);
      end else if (line_has_prefix("AT$IF=")) begin
         digits = read_decimal(RADIO_FIRST_OFFSET, RADIO_FIRST_DIGITS, cca);
         void'(read_decimal(RADIO_FIRST_OFFSET + 1 + digits, RADIO_SECOND_DIGITS, txp));
         r.command = CMD_RADIO;
         r.cca_threshold = cca;
         r.tx_power = txp;
         fresh_results.push_back(r);
      end else if (line_has_prefix("AT")) begin
         r.command = CMD_AT;
         fresh_results.push_back(r);
      end
      line_len = 0;
      return 1'b1;
   endfunction

   function automatic logic [7:0] terminator();
      return ($urandom_range(0, 1) != 0) ? CH_LF : CH_SEMI;
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == CH_LF || b == CH_SEMI);
      return b;
   endfunction

   function automatic logic [7:0] digit_byte();
      return CH_0 + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] capital_byte();
      return CH_A + 8'($urandom_range(0, 25));
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // Called just after a rising edge; returns just after the edge of the transfer.
   task automatic send_byte(input logic [7:0] rx, input bit typed,
                            input parse_result_type want);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      if (predict_byte(rx)) begin
         items_sent++;
      end
      if (typed) begin
         expected_results.push_back(want);
      end else begin
         foreach (fresh_results[i]) begin
            expected_results.push_back(fresh_results[i]);
         end
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_line(input line_kind_type kind, input int send_len);
      logic [7:0] line_q[$];
      int         n;
      case (kind)
         LINE_SEND: begin
            if (send_len < 0) begin
               send_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 27)
                                                      : $urandom_range(0, 12);
            end
            line_q.push_back(CH_S);
            line_q.push_back(CH_F);
            line_q.push_back(CH_M);
            line_q.push_back(8'(send_len));
            n = send_len;
            if ($urandom_range(0, 6) == 0) begin
               n = $urandom_range(0, send_len);
            end
            if (n > 40) begin
               n = 40;
            end
            repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
            line_q.push_back(terminator());
         end
         LINE_RADIO: begin
            line_q.push_back(CH_A);
            line_q.push_back(CH_T);
            line_q.push_back(CH_DOLLAR);
            line_q.push_back(CH_I);
            line_q.push_back(CH_F);
            line_q.push_back(CH_EQUAL);
            // Mostly the values land at their offsets; a short line reads old bytes.
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 9) : 10;
            repeat (n) line_q.push_back(plain_byte());
            repeat ($urandom_range(0, 6)) line_q.push_back(digit_byte());
            line_q.push_back(($urandom_range(0, 3) == 0) ? digit_byte() : plain_byte());
            repeat ($urandom_range(0, 4)) line_q.push_back(digit_byte());
            line_q.push_back(terminator());
         end
         LINE_VERSION: begin
            line_q.push_back(CH_A);
            line_q.push_back(CH_T);
            line_q.push_back(CH_I);
            line_q.push_back(CH_1);
            line_q.push_back(CH_3);
            repeat ($urandom_range(0, 2)) line_q.push_back(capital_byte());
            line_q.push_back(terminator());
         end
         LINE_AT: begin
            line_q.push_back(CH_A);
            line_q.push_back(CH_T);
            repeat ($urandom_range(0, 3)) line_q.push_back(plain_byte());
            line_q.push_back(terminator());
         end
         LINE_NOMATCH: begin
            line_q.push_back(capital_byte());
            repeat ($urandom_range(0, 6)) line_q.push_back(plain_byte());
            line_q.push_back(terminator());
         end
         LINE_NOISE: begin
            repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
         end
         LINE_LONG: begin
            line_q.push_back(CH_A);
            line_q.push_back(CH_T);
            repeat ($urandom_range(34, 40)) line_q.push_back(plain_byte());
            line_q.push_back(terminator());
         end
         default: begin
            line_q.push_back(terminator());
         end
      endcase
      foreach (line_q[i]) begin
         send_byte(line_q[i], 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      parse_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with nothing expected, command %0d node %0h char %0h",
                     $time, rsp_command, rsp_node_id, rsp_hex_char);
            errors++;
         end else begin
            want = expected_results.pop_front();
            check_field("command", 16'(want.command), 16'(rsp_command));
            check_field("node_id", want.node_id, rsp_node_id);
            check_field("cca_threshold", 16'(want.cca_threshold), 16'(rsp_cca_threshold));
            check_field("tx_power", 16'(want.tx_power), 16'(rsp_tx_power));
            check_field("hex_char", 16'(want.hex_char), 16'(rsp_hex_char));
            check_field("char_valid", 16'(want.char_valid), 16'(rsp_char_valid));
            check_field("last", 16'(want.last), 16'(rsp_last));
         end
      end
      if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still expected", $time,
                  expected_results.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      parse_result_type want;
      line_kind_type    kind;
      int               pick;
      for (int i = 0; i < LINE_DEPTH; i++) begin
         line_buf[i] = 8'h00;
      end
      line_len = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 6;
      recv_idle_pct = 84;
      foreach (script[i]) begin
         want = '0;
         want.command = script[i].command;
         want.node_id = script[i].node_id;
         want.last = 1'b1;
         send_byte(script[i].rx_byte, script[i].typed, want);
      end

      items_sent = 0;
      for (int phase = 0; phase < 3; phase++) begin
         drain_results();
         case (phase)
            0: begin
               send_idle_pct = 6;
               recv_idle_pct = 84;
            end
            1: begin
               send_idle_pct = 84;
               recv_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               // The receiver holds off while full sends keep coming, so the
               // block backs up into its input.
               hold_requests++;
               send_line(LINE_SEND, MAX_PAYLOAD_BYTES);
               send_line(LINE_SEND, MAX_PAYLOAD_BYTES);
               send_line(LINE_RADIO, -1);
            end
         endcase
         while (items_sent < (phase + 1) * RANDOM_ITEMS / 3) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               kind = LINE_SEND;
            end else if (pick < 50) begin
               kind = LINE_RADIO;
            end else if (pick < 60) begin
               kind = LINE_VERSION;
            end else if (pick < 70) begin
               kind = LINE_AT;
            end else if (pick < 80) begin
               kind = LINE_NOMATCH;
            end else if (pick < 90) begin
               kind = LINE_NOISE;
            end else if (pick < 95) begin
               kind = LINE_LONG;
            end else begin
               kind = LINE_TERM;
            end
            send_line(kind, -1);
         end
      end

      // A send whose length can never fit leaves the store full for good, so
      // it comes last.
      send_line(LINE_SEND, 200);
      send_line(LINE_AT, -1);
      send_line(LINE_VERSION, -1);

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
